// ===== hw/rtl/market_feed_frame_parser_unit_defines.svh =====
// assertion macros for the market feed frame parser
`ifndef MARKET_FEED_FRAME_PARSER_UNIT_DEFINES_SVH
`define MARKET_FEED_FRAME_PARSER_UNIT_DEFINES_SVH
`ifndef SYNTH
`define MFP_ASSERT_ALWAYS(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("mfp assertion failed");
`define MFP_ASSERT_IMPLIES(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mfp assertion failed");
`define MFP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mfp assertion failed");
`else
`define MFP_ASSERT_ALWAYS(lbl, expr)
`define MFP_ASSERT_IMPLIES(lbl, ante, cons)
`define MFP_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== hw/rtl/mfp_pkg.sv =====
// shared types and constants of the market feed frame parser
`timescale 1ns / 1ps
package mfp_pkg;
	localparam int WIN_DEPTH = 44;
	localparam int HDR_BYTES = 16;
	localparam int CHK_BYTES = 4;
	localparam int TRADE_LEN = 12;
	localparam int QUOTE_LEN = 24;
	localparam int BEAT_MSG = HDR_BYTES + CHK_BYTES;
	localparam int TRADE_MSG = HDR_BYTES + TRADE_LEN + CHK_BYTES;
	localparam int QUOTE_MSG = HDR_BYTES + QUOTE_LEN + CHK_BYTES;
	localparam logic [15:0] TYPE_TRADE = 16'h0001;
	localparam logic [15:0] TYPE_QUOTE = 16'h0002;
	localparam logic [15:0] TYPE_BEAT = 16'h0003;

	typedef logic [5:0] fill_t;
	typedef logic [7:0] byte_t;

	typedef enum logic [1:0] {
		KIND_TRADE = 2'd0,
		KIND_QUOTE = 2'd1,
		KIND_BEAT = 2'd2,
		KIND_NONE = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		SH_NONE,
		SH_ONE,
		SH_FRAME
	} shift_t;

	typedef struct packed {
		logic append;
		shift_t shift;
		logic capture;
		logic cap_slot;
		logic rd_slot;
	} cmd_t;

	typedef struct packed {
		logic enough_hdr;
		kind_t kind;
		logic enough_msg;
		logic csum_ok;
	} status_t;

	typedef struct packed {
		kind_t kind;
		logic [31:0] seq;
		logic [63:0] ts;
		logic [15:0] sym;
		logic [63:0] p1;
		logic [31:0] q1;
		logic [63:0] p2;
		logic [31:0] q2;
	} tick_t;

	function automatic fill_t frame_len(kind_t k);
		case (k)
			KIND_TRADE: frame_len = fill_t'(TRADE_MSG);
			KIND_QUOTE: frame_len = fill_t'(QUOTE_MSG);
			default: frame_len = fill_t'(BEAT_MSG);
		endcase
	endfunction
endpackage

// ===== hw/rtl/mfp_channels.sv =====
// handshake channels for feed bytes and tick results
`timescale 1ns / 1ps
interface mfp_byte_if;
	logic valid;
	logic ready;
	logic [7:0] stream_byte;
	modport source (output valid, output stream_byte, input ready);
	modport sink (input valid, input stream_byte, output ready);
endinterface

interface mfp_tick_if;
	logic valid;
	logic ready;
	logic [1:0] tick_kind;
	logic [31:0] seq_number;
	logic [63:0] time_stamp;
	logic [15:0] symbol_code;
	logic [63:0] first_price;
	logic [31:0] first_qty;
	logic [63:0] second_price;
	logic [31:0] second_qty;
	logic last_of_run;
	modport source (output valid, output tick_kind, output seq_number, output time_stamp,
		output symbol_code, output first_price, output first_qty, output second_price,
		output second_qty, output last_of_run, input ready);
	modport sink (input valid, input tick_kind, input seq_number, input time_stamp,
		input symbol_code, input first_price, input first_qty, input second_price,
		input second_qty, input last_of_run, output ready);
endinterface

// ===== hw/rtl/mfp_datapath.sv =====
// byte window, frame checks and tick slots
`timescale 1ns / 1ps
module mfp_datapath (
	input logic clk,
	input logic arst_n,
	input mfp_pkg::byte_t in_byte,
	input mfp_pkg::cmd_t cmd,
	output mfp_pkg::status_t status,
	output mfp_pkg::tick_t tick
);
	mfp_pkg::byte_t win_q [mfp_pkg::WIN_DEPTH];
	mfp_pkg::byte_t win_d [mfp_pkg::WIN_DEPTH];
	mfp_pkg::fill_t fill_q;
	mfp_pkg::status_t st_q;
	mfp_pkg::status_t st_c;
	mfp_pkg::tick_t slot_q [2];
	mfp_pkg::tick_t cap_c;
	logic [7:0] x_beat, x_trade, x_quote;
	logic [31:0] c_beat, c_trade, c_quote;
	logic [15:0] type_w;

	function automatic logic [63:0] le8(mfp_pkg::byte_t w [mfp_pkg::WIN_DEPTH], int at);
		le8 = {w[at+7], w[at+6], w[at+5], w[at+4], w[at+3], w[at+2], w[at+1], w[at]};
	endfunction

	function automatic logic [31:0] le4(mfp_pkg::byte_t w [mfp_pkg::WIN_DEPTH], int at);
		le4 = {w[at+3], w[at+2], w[at+1], w[at]};
	endfunction

	// xor sums over header, header plus trade payload, header plus quote payload
	always_comb begin
		logic [mfp_pkg::HDR_BYTES-1:0] col_h;
		logic [mfp_pkg::TRADE_LEN-1:0] col_t;
		logic [mfp_pkg::QUOTE_LEN-mfp_pkg::TRADE_LEN-1:0] col_q;
		for (int b = 0; b < 8; b++) begin
			for (int i = 0; i < mfp_pkg::HDR_BYTES; i++) col_h[i] = win_q[i][b];
			for (int i = 0; i < mfp_pkg::TRADE_LEN; i++)
				col_t[i] = win_q[mfp_pkg::HDR_BYTES+i][b];
			for (int i = 0; i < mfp_pkg::QUOTE_LEN - mfp_pkg::TRADE_LEN; i++)
				col_q[i] = win_q[mfp_pkg::HDR_BYTES+mfp_pkg::TRADE_LEN+i][b];
			x_beat[b] = ^col_h;
			x_trade[b] = (^col_h) ^ (^col_t);
			x_quote[b] = (^col_h) ^ (^col_t) ^ (^col_q);
		end
	end

	assign c_beat = le4(win_q, mfp_pkg::HDR_BYTES);
	assign c_trade = le4(win_q, mfp_pkg::HDR_BYTES + mfp_pkg::TRADE_LEN);
	assign c_quote = le4(win_q, mfp_pkg::HDR_BYTES + mfp_pkg::QUOTE_LEN);
	assign type_w = {win_q[1], win_q[0]};

	always_comb begin
		case (type_w)
			mfp_pkg::TYPE_TRADE: st_c.kind = mfp_pkg::KIND_TRADE;
			mfp_pkg::TYPE_QUOTE: st_c.kind = mfp_pkg::KIND_QUOTE;
			mfp_pkg::TYPE_BEAT: st_c.kind = mfp_pkg::KIND_BEAT;
			default: st_c.kind = mfp_pkg::KIND_NONE;
		endcase
		case (st_c.kind)
			mfp_pkg::KIND_TRADE: st_c.csum_ok = (c_trade == {24'd0, x_trade});
			mfp_pkg::KIND_QUOTE: st_c.csum_ok = (c_quote == {24'd0, x_quote});
			default: st_c.csum_ok = (c_beat == {24'd0, x_beat});
		endcase
		st_c.enough_hdr = (fill_q >= mfp_pkg::fill_t'(mfp_pkg::BEAT_MSG));
		st_c.enough_msg = (fill_q >= mfp_pkg::frame_len(st_c.kind));
	end

	always_comb begin
		cap_c.kind = st_q.kind;
		cap_c.seq = le4(win_q, 2);
		cap_c.ts = le8(win_q, 6);
		cap_c.sym = {win_q[15], win_q[14]};
		cap_c.p1 = '0;
		cap_c.q1 = '0;
		cap_c.p2 = '0;
		cap_c.q2 = '0;
		if (st_q.kind != mfp_pkg::KIND_BEAT) begin
			cap_c.p1 = le8(win_q, mfp_pkg::HDR_BYTES);
			cap_c.q1 = le4(win_q, mfp_pkg::HDR_BYTES + 8);
		end
		if (st_q.kind == mfp_pkg::KIND_QUOTE) begin
			cap_c.p2 = le8(win_q, mfp_pkg::HDR_BYTES + 12);
			cap_c.q2 = le4(win_q, mfp_pkg::HDR_BYTES + 20);
		end
	end

	// window next value: append at the fill point (shifting the front out when full) or drop from the front
	always_comb begin
		win_d = win_q;
		if (cmd.append) begin
			if (fill_q == mfp_pkg::fill_t'(mfp_pkg::WIN_DEPTH)) begin
				for (int i = 0; i < mfp_pkg::WIN_DEPTH - 1; i++) win_d[i] = win_q[i+1];
				win_d[mfp_pkg::WIN_DEPTH-1] = in_byte;
			end else begin
				win_d[fill_q] = in_byte;
			end
		end else if (cmd.shift == mfp_pkg::SH_ONE) begin
			for (int i = 0; i < mfp_pkg::WIN_DEPTH - 1; i++) win_d[i] = win_q[i+1];
		end else if (cmd.shift == mfp_pkg::SH_FRAME) begin
			case (st_q.kind)
				mfp_pkg::KIND_TRADE:
					for (int i = 0; i < mfp_pkg::WIN_DEPTH - mfp_pkg::TRADE_MSG; i++)
						win_d[i] = win_q[i+mfp_pkg::TRADE_MSG];
				mfp_pkg::KIND_BEAT:
					for (int i = 0; i < mfp_pkg::WIN_DEPTH - mfp_pkg::BEAT_MSG; i++)
						win_d[i] = win_q[i+mfp_pkg::BEAT_MSG];
				// a quote fills the whole window, nothing remains to move
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		win_q <= win_d;
		if (cmd.capture) slot_q[cmd.cap_slot] <= cap_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			st_q <= '0;
		end else begin
			st_q <= st_c;
			if (cmd.append) begin
				if (fill_q != mfp_pkg::fill_t'(mfp_pkg::WIN_DEPTH)) fill_q <= fill_q + 6'd1;
			end else if (cmd.shift == mfp_pkg::SH_ONE) begin
				fill_q <= fill_q - 6'd1;
			end else if (cmd.shift == mfp_pkg::SH_FRAME) begin
				fill_q <= fill_q - mfp_pkg::frame_len(st_q.kind);
			end
		end
	end

	assign status = st_q;
	assign tick = slot_q[cmd.rd_slot];
endmodule

// ===== hw/rtl/mfp_ctrl.sv =====
// scan sequencer of the market feed frame parser
`timescale 1ns / 1ps
`include "market_feed_frame_parser_unit_defines.svh"
module mfp_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input logic out_ready,
	output logic out_last,
	input mfp_pkg::status_t status,
	output mfp_pkg::cmd_t cmd
);
	typedef enum logic [1:0] {S_IDLE, S_EVAL, S_DEC, S_EMIT} state_t;

	state_t state_q;
	logic [1:0] cnt_q;
	logic eidx_q;
	logic out_valid_q;
	logic done_c;

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_last = (eidx_q == (cnt_q == 2'd2));
	assign done_c = !status.enough_hdr ||
		(status.kind != mfp_pkg::KIND_NONE && !status.enough_msg);

	always_comb begin
		cmd = '0;
		cmd.append = in_valid && in_ready;
		cmd.rd_slot = eidx_q;
		cmd.cap_slot = cnt_q[0];
		if (state_q == S_DEC && !done_c) begin
			if (status.kind == mfp_pkg::KIND_NONE || !status.csum_ok) begin
				cmd.shift = mfp_pkg::SH_ONE;
			end else begin
				cmd.shift = mfp_pkg::SH_FRAME;
				cmd.capture = (cnt_q != 2'd2);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			eidx_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					cnt_q <= '0;
					eidx_q <= 1'b0;
					if (in_valid) state_q <= S_EVAL;
				end
				S_EVAL: state_q <= S_DEC;
				S_DEC: begin
					if (done_c) begin
						if (cnt_q == 2'd0) begin
							state_q <= S_IDLE;
						end else begin
							state_q <= S_EMIT;
							out_valid_q <= 1'b1;
						end
					end else begin
						if (cmd.capture) cnt_q <= cnt_q + 2'd1;
						state_q <= S_EVAL;
					end
				end
				S_EMIT: begin
					if (out_ready) begin
						if (out_last) begin
							out_valid_q <= 1'b0;
							state_q <= S_IDLE;
						end else begin
							eidx_q <= 1'b1;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`MFP_ASSERT_ALWAYS(a_no_overlap, !(in_ready && out_valid))
	`MFP_ASSERT_ALWAYS(a_cnt_bound, cnt_q != 2'd3)
	`MFP_ASSERT_NEXT(a_accept_scans, in_valid && in_ready, state_q == S_EVAL)
	`MFP_ASSERT_IMPLIES(a_emit_has_tick, out_valid, cnt_q != 2'd0)
endmodule

// ===== hw/rtl/market_feed_frame_parser_unit.sv =====
// market feed frame parser: byte stream in, one tick per valid frame out
// in_ch carries one feed byte per transfer; out_ch carries one tick per transfer,
// with last_of_run set on the final tick that a byte resolves (at most two per byte).
// a byte is taken only while the scanner is idle; each scan step (dropping one
// byte or consuming a frame) passes through the EVAL and DEC states, with the
// frame checks held in the window check register between them.
// ticks are held in two slots and offered once the scan is done, one per cycle
// while the receiver is ready; a stalled receiver holds the current tick and the
// input stays closed until the last tick is transferred.
// the window is 44 byte registers that shift from the front; frame checks and
// field extraction always read fixed offsets at the window head.
// reset empties the window and the scanner; the tick slots are written before
// they are offered, so they need no reset and no clearing pass.
`timescale 1ns / 1ps
module market_feed_frame_parser_unit (
	input logic clk,
	input logic arst_n,
	mfp_byte_if.sink in_ch,
	mfp_tick_if.source out_ch
);
	mfp_pkg::cmd_t cmd;
	mfp_pkg::status_t status;
	mfp_pkg::tick_t tick;
	logic last;

	mfp_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_ch.valid),
		.in_ready(in_ch.ready),
		.out_valid(out_ch.valid),
		.out_ready(out_ch.ready),
		.out_last(last),
		.status(status),
		.cmd(cmd)
	);

	mfp_datapath u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.in_byte(in_ch.stream_byte),
		.cmd(cmd),
		.status(status),
		.tick(tick)
	);

	assign out_ch.tick_kind = tick.kind;
	assign out_ch.seq_number = tick.seq;
	assign out_ch.time_stamp = tick.ts;
	assign out_ch.symbol_code = tick.sym;
	assign out_ch.first_price = tick.p1;
	assign out_ch.first_qty = tick.q1;
	assign out_ch.second_price = tick.p2;
	assign out_ch.second_qty = tick.q2;
	assign out_ch.last_of_run = last;
endmodule
